@@ design/nnaq_pkg.sv @@
// Shared package for the nearest-node attractor query unit.
// Holds sizes, command and status codes, and the payload and link struct types.
// No dependencies.
`timescale 1ns / 1ps

package nnaq_pkg;

  // Table size and derived widths.
  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  // Arithmetic widths.
  localparam int COORD_W  = 16;
  localparam int ABS_W    = 16;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int DIST_W   = 34;
  localparam int RADIUS_W = 14;
  localparam int KILLD_W  = RADIUS_W + 1;
  localparam int KSQ_W    = 2 * KILLD_W;
  localparam int NODE_W   = 3 * COORD_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(5);

  // Command codes.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_MARK   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_sq_distance;
    logic              killed;
    logic [1:0]        status;
  } out_item_t;

  // A 3-D point.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Node read from the table, entering the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } node_rd_t;

  // Squared distance leaving the distance pipeline.
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq;
  } dist_t;

  // Running result of the scan.
  typedef struct packed {
    logic              killed;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq;
  } best_t;

endpackage

@@ design/nearest_node_attractor_query_unit.sv @@
// Nearest-node attractor query unit: a table of up to MAX_NODES 3-D nodes with an exact
// squared-distance search. Clear, append and mark-boundary commands are answered in the
// cycle after they are accepted. For a query the sequencer reads one node per cycle from
// the node RAM and feeds a shared three-stage distance pipeline, whose result updates the
// nearest node and the kill flag in a single pass. The input is stalled until the result
// is loaded into the output register. No clearing pass is needed after reset.
// Depends on nnaq_pkg, nnaq_ram, nnaq_dist and nnaq_best.
`timescale 1ns / 1ps

module nearest_node_attractor_query_unit import nnaq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  in_item_t            item,
  output logic                result_valid,
  input  logic                result_stall,
  output out_item_t           result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    node_count;
  logic [CNT_W-1:0]    generation_start;
  logic [RADIUS_W-1:0] node_radius;
  logic [CNT_W-1:0]    scan_addr;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;
  point_t              attr;
  logic [KSQ_W-1:0]    kill_sq;
  logic [KILLD_W-1:0]  kill_d;

  logic                accept;
  logic                out_free;
  logic                issue;
  logic                table_full;
  logic                ram_we;
  logic [NODE_W-1:0]   ram_rdata;
  node_rd_t            node_rd;
  dist_t               node_sq;
  logic                pipe_busy;
  logic                scan_start;
  best_t               best;
  logic                result_load;
  out_item_t           result_next;

  // Handshake and control decode.
  always_comb begin
    out_free   = !result_valid || !result_stall;
    item_stall = (state != ST_IDLE) || !out_free;
    accept     = item_valid && !item_stall;
    table_full = node_count >= CNT_W'(MAX_NODES);
    ram_we     = accept && (item.kind == KIND_APPEND) && !table_full;
    issue      = (state == ST_SCAN) && (scan_addr < node_count);
    scan_start = accept && (item.kind == KIND_QUERY);
    kill_d     = {node_radius, 1'b0};
  end

  // Next output transaction: immediate commands and empty-table queries on accept, query answers when done.
  always_comb begin
    result_load = 1'b0;
    result_next = '0;
    if (accept) begin
      unique case (item.kind)
        KIND_CLEAR: begin
          result_load = 1'b1;
        end
        KIND_APPEND: begin
          result_load = 1'b1;
          if (table_full) begin
            result_next.status = STATUS_FULL;
          end else begin
            result_next.nearest_index = node_count[IDX_W-1:0];
          end
        end
        KIND_MARK: begin
          result_load = 1'b1;
        end
        default: begin
          if (node_count == '0) begin
            result_load        = 1'b1;
            result_next.status = STATUS_EMPTY;
          end
        end
      endcase
    end else if ((state == ST_DONE) && out_free) begin
      result_load        = 1'b1;
      result_next.killed = best.killed;
      if (!best.killed) begin
        result_next.nearest_index       = best.idx;
        result_next.nearest_sq_distance = best.sq;
      end
    end
  end

  assign cfg_ready = 1'b1;

  // Node table.
  nnaq_ram #(
    .WIDTH(NODE_W),
    .DEPTH(MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(node_count[IDX_W-1:0]),
    .wdata({item.point_x, item.point_y, item.point_z}),
    .raddr(scan_addr[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign node_rd.valid = rd_valid;
  assign node_rd.idx   = rd_idx;
  assign node_rd.pt    = ram_rdata;

  // Shared distance pipeline.
  nnaq_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .node  (node_rd),
    .attr  (attr),
    .sq_out(node_sq),
    .busy  (pipe_busy)
  );

  // Nearest and kill tracking.
  nnaq_best u_best (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .sq_in    (node_sq),
    .gen_start(generation_start),
    .kill_sq  (kill_sq),
    .best     (best)
  );

  // Sequencer, table state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      node_count       <= '0;
      generation_start <= '0;
      node_radius      <= RADIUS_RESET;
      rd_valid         <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_radius <= cfg_data;
      end
      rd_valid     <= issue;
      rd_idx       <= scan_addr[IDX_W-1:0];
      result_valid <= result_load || (result_valid && result_stall);
      if (result_load) begin
        result <= result_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.kind)
              KIND_CLEAR: begin
                node_count       <= '0;
                generation_start <= '0;
              end
              KIND_APPEND: begin
                if (!table_full) begin
                  node_count <= node_count + CNT_W'(1);
                end
              end
              KIND_MARK: begin
                generation_start <= node_count;
              end
              default: begin
                if (node_count != '0) begin
                  attr.x    <= item.point_x;
                  attr.y    <= item.point_y;
                  attr.z    <= item.point_z;
                  kill_sq   <= KSQ_W'(kill_d) * KSQ_W'(kill_d);
                  scan_addr <= '0;
                  state     <= ST_SCAN;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !pipe_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The node count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(MAX_NODES))
    else $error("node count exceeds table size");

  // The generation boundary never lies past the end of the table.
  a_gen_bound: assert property (@(posedge clk) disable iff (rst)
    generation_start <= node_count)
    else $error("generation boundary beyond node count");

  // A finished scan delivers its result and returns to idle.
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> result_valid && (state == ST_IDLE))
    else $error("scan result not delivered");

  // A query on a non-empty table starts a scan.
  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    accept && (item.kind == KIND_QUERY) && (node_count != '0) |=> state == ST_SCAN)
    else $error("query did not start a scan");

  // A killed attractor reports no nearest node.
  a_killed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.killed |->
      (result.nearest_index == '0) && (result.nearest_sq_distance == '0) &&
      (result.status == STATUS_OK))
    else $error("killed result carries a nearest node");

endmodule

@@ design/nnaq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nnaq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/nnaq_dist.sv @@
// Squared-distance pipeline: one node per cycle, three stages.
// Depends on nnaq_pkg.
`timescale 1ns / 1ps

module nnaq_dist import nnaq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  node_rd_t node,
  input  point_t   attr,
  output dist_t    sq_out,
  output logic     busy
);

  // Absolute difference of two signed coordinates; always fits in ABS_W bits.
  function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[ABS_W-1:0];
  endfunction

  logic             s1_valid, s2_valid, s3_valid;
  logic [IDX_W-1:0] s1_idx, s2_idx, s3_idx;
  logic [ABS_W-1:0] s1_ax, s1_ay, s1_az;
  logic [SQ_W-1:0]  s2_sx, s2_sy, s2_sz;
  logic [DIST_W-1:0] s3_sq;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= node.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1 differences, stage 2 squares, stage 3 sum.
  always_ff @(posedge clk) begin
    s1_idx <= node.idx;
    s1_ax  <= abs_diff(attr.x, node.pt.x);
    s1_ay  <= abs_diff(attr.y, node.pt.y);
    s1_az  <= abs_diff(attr.z, node.pt.z);
    s2_idx <= s1_idx;
    s2_sx  <= SQ_W'(s1_ax) * SQ_W'(s1_ax);
    s2_sy  <= SQ_W'(s1_ay) * SQ_W'(s1_ay);
    s2_sz  <= SQ_W'(s1_az) * SQ_W'(s1_az);
    s3_idx <= s2_idx;
    s3_sq  <= DIST_W'(s2_sx) + DIST_W'(s2_sy) + DIST_W'(s2_sz);
  end

  assign sq_out.valid = s3_valid;
  assign sq_out.idx   = s3_idx;
  assign sq_out.sq    = s3_sq;
  assign busy         = s1_valid | s2_valid | s3_valid;

endmodule

@@ design/nnaq_best.sv @@
// Scan tracker: keeps the nearest node so far and the kill flag.
// Depends on nnaq_pkg.
`timescale 1ns / 1ps

module nnaq_best import nnaq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dist_t            sq_in,
  input  logic [CNT_W-1:0] gen_start,
  input  logic [KSQ_W-1:0] kill_sq,
  output best_t            best
);

  logic              best_valid;
  logic              killed;
  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_sq;
  logic              in_gen;
  logic              in_kill;
  logic              closer;

  always_comb begin
    in_gen  = {1'b0, sq_in.idx} >= gen_start;
    in_kill = sq_in.sq < DIST_W'(kill_sq);
    closer  = !best_valid || (sq_in.sq < best_sq);
  end

  // Strictly-closer update keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      killed     <= 1'b0;
    end else if (start) begin
      best_valid <= 1'b0;
      killed     <= 1'b0;
    end else if (sq_in.valid) begin
      if (in_gen && in_kill) begin
        killed <= 1'b1;
      end
      if (closer) begin
        best_valid <= 1'b1;
        best_idx   <= sq_in.idx;
        best_sq    <= sq_in.sq;
      end
    end
  end

  assign best.killed = killed;
  assign best.idx    = best_idx;
  assign best.sq     = best_sq;

endmodule

@@ sim/nearest_node_attractor_query_unit_checker.sv @@
// Checker for the nearest-node attractor query unit: watches the command, result and
// configuration channels, predicts every answer and compares it field by field.
// Depends on nnaq_pkg.
`timescale 1ns / 1ps

module nearest_node_attractor_query_unit_checker import nnaq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  in_item_t            item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  out_item_t           result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data,
  output int                  mismatch_total,
  output int                  answers_owed
);

  // Shadow copy of the node table and its bookkeeping.
  point_t              node_tab [MAX_NODES];
  logic [CNT_W-1:0]    tab_count;
  logic [CNT_W-1:0]    gen_mark;
  logic [RADIUS_W-1:0] radius;

  // Answers predicted for accepted commands, oldest first.
  out_item_t answer_q [$];
  out_item_t oldest;

  // Exact squared distance between two points.
  function automatic logic [DIST_W-1:0] span_sq(point_t a, point_t b);
    logic signed [COORD_W:0] dx, dy, dz;
    logic [DIST_W-1:0]       mx, my, mz;
    dx = a.x - b.x;
    dy = a.y - b.y;
    dz = a.z - b.z;
    mx = dx[COORD_W] ? DIST_W'(-dx) : DIST_W'(dx);
    my = dy[COORD_W] ? DIST_W'(-dy) : DIST_W'(dy);
    mz = dz[COORD_W] ? DIST_W'(-dz) : DIST_W'(dz);
    return mx * mx + my * my + mz * mz;
  endfunction

  // Applies one command to the shadow table and returns the answer it must produce.
  function automatic out_item_t predict_answer(in_item_t cmd);
    out_item_t         ans;
    point_t            pt;
    logic [DIST_W-1:0] reach, kill_sq, d, best;
    logic [IDX_W-1:0]  best_idx;
    ans  = '0;
    pt.x = cmd.point_x;
    pt.y = cmd.point_y;
    pt.z = cmd.point_z;
    case (cmd.kind)
      KIND_CLEAR: begin
        tab_count = '0;
        gen_mark  = '0;
      end
      KIND_APPEND: begin
        if (tab_count < CNT_W'(MAX_NODES)) begin
          node_tab[tab_count[IDX_W-1:0]] = pt;
          ans.nearest_index = tab_count[IDX_W-1:0];
          tab_count = tab_count + CNT_W'(1);
        end else begin
          ans.status = STATUS_FULL;
        end
      end
      KIND_MARK: begin
        gen_mark = tab_count;
      end
      default: begin
        if (tab_count == '0) begin
          ans.status = STATUS_EMPTY;
        end else begin
          // Kill test covers only nodes added since the generation boundary.
          reach   = DIST_W'(radius) << 1;
          kill_sq = reach * reach;
          for (int j = int'(gen_mark); j < int'(tab_count); j++) begin
            if (span_sq(pt, node_tab[j]) < kill_sq) ans.killed = 1'b1;
          end
          // Nearest search over the whole table; a tie keeps the lower index.
          if (!ans.killed) begin
            best     = span_sq(pt, node_tab[0]);
            best_idx = '0;
            for (int j = 1; j < int'(tab_count); j++) begin
              d = span_sq(pt, node_tab[j]);
              if (d < best) begin
                best     = d;
                best_idx = IDX_W'(j);
              end
            end
            ans.nearest_index       = best_idx;
            ans.nearest_sq_distance = best;
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endfunction

  // Follow every transaction on the three channels.
  always @(posedge clk) begin
    if (rst) begin
      tab_count = '0;
      gen_mark  = '0;
      radius    = RADIUS_RESET;
      answer_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (answer_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatch_total++;
        end else begin
          oldest = answer_q.pop_front();
          check_field("nearest_index", oldest.nearest_index, result.nearest_index);
          check_field("nearest_sq_distance", oldest.nearest_sq_distance,
                      result.nearest_sq_distance);
          check_field("killed", oldest.killed, result.killed);
          check_field("status", oldest.status, result.status);
        end
      end
      if (cfg_valid && cfg_ready) radius = cfg_data;
      if (item_valid && !item_stall) answer_q.insert(answer_q.size(), predict_answer(item));
    end
    answers_owed = answer_q.size();
  end

endmodule

@@ sim/nearest_node_attractor_query_unit_tb.sv @@
// Testbench top for the nearest-node attractor query unit: drives commands and radius
// writes with random bursts and receiver stalls, and reports the verdict.
// Depends on nnaq_pkg, the unit itself and nearest_node_attractor_query_unit_checker.
`timescale 1ns / 1ps

module nearest_node_attractor_query_unit_tb;
  import nnaq_pkg::*;

  localparam int RANDOM_ITEMS = 580;
  localparam int LONG_HOLD    = 400;
  localparam int TABLE_CAP    = 200;

  localparam logic signed [COORD_W-1:0] C_MAX  = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] C_MIN  = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_ZERO = 16'sh0000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  in_item_t            item         = '0;
  logic                result_stall = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic [RADIUS_W-1:0] cfg_data     = '0;
  logic                item_stall;
  logic                result_valid;
  logic                cfg_ready;
  out_item_t           result;

  int mismatch_total;
  int answers_owed;
  int burst_left = 0;
  int table_fill = 0;
  int issued     = 0;
  bit hold_req   = 1'b0;

  nearest_node_attractor_query_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  nearest_node_attractor_query_unit_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_total (mismatch_total),
    .answers_owed   (answers_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Coordinate with extra weight on the extremes.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return C_ZERO;
      3:       return -16'sd1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Coordinate within spread of a center; wraps at the 16-bit boundary.
  function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c,
                                                           int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    return COORD_W'(v);
  endfunction

  // Offers one command and holds it until accepted, then maybe opens a gap.
  task automatic send_item(in_item_t cmd);
    int gap;
    item       <= cmd;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic issue(logic [1:0] kind, logic signed [COORD_W-1:0] px,
                       logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
    in_item_t cmd;
    cmd.kind    = kind;
    cmd.point_x = px;
    cmd.point_y = py;
    cmd.point_z = pz;
    if (kind == KIND_CLEAR) table_fill = 0;
    else if (kind == KIND_APPEND && table_fill < MAX_NODES) table_fill++;
    send_item(cmd);
  endtask

  // Waits until every outstanding answer has come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: a changing stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    int span;
    int tick;
    int hold_cnt;
    span = 0;
    tick = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 200);
        end
        span--;
        tick++;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("[nearest_node_attractor_query_unit] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int n_app;
    int n_q;
    int mark_at;
    int spread;
    int rad;
    int start_count;
    logic signed [COORD_W-1:0] cx, cy, cz;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset radius: empty table, extremes, kills, ties.
    issue(KIND_QUERY, C_MAX, C_MIN, C_ZERO);
    issue(KIND_APPEND, C_MAX, C_MIN, C_MAX);
    issue(KIND_APPEND, C_MIN, C_MAX, C_MIN);
    issue(KIND_QUERY, C_MIN, C_MAX, C_MIN);
    issue(KIND_MARK, C_MAX, C_MAX, C_MAX);
    issue(KIND_QUERY, C_MAX, C_MIN, C_MAX);
    issue(KIND_QUERY, C_MIN, C_MIN, C_MIN);
    issue(KIND_APPEND, 16'sd100, C_ZERO, C_ZERO);
    issue(KIND_APPEND, -16'sd100, C_ZERO, C_ZERO);
    issue(KIND_QUERY, C_ZERO, C_ZERO, C_ZERO);
    issue(KIND_QUERY, 16'sd105, C_ZERO, C_ZERO);
    issue(KIND_QUERY, 16'sd110, C_ZERO, C_ZERO);
    issue(KIND_CLEAR, C_MIN, C_MAX, C_MIN);
    issue(KIND_QUERY, C_ZERO, C_ZERO, C_ZERO);
    issue(KIND_APPEND, C_MAX, C_MIN, C_MAX);
    issue(KIND_QUERY, C_MIN, C_MAX, C_MIN);
    drain();

    // Largest radius: a far attractor survives, a moderately near one is killed.
    write_radius({RADIUS_W{1'b1}});
    issue(KIND_QUERY, C_ZERO, C_ZERO, C_ZERO);
    issue(KIND_QUERY, 16'sd16000, -16'sd16000, 16'sd16000);
    issue(KIND_QUERY, C_MIN, C_MAX, C_MIN);
    drain();

    // Zero radius: nothing is ever killed, even at distance zero.
    write_radius('0);
    issue(KIND_QUERY, C_MAX, C_MIN, C_MAX);
    issue(KIND_APPEND, C_ZERO, C_ZERO, C_ZERO);
    issue(KIND_QUERY, C_ZERO, C_ZERO, C_ZERO);
    drain();

    // Fill the table to capacity, overflow it, and search the full table.
    issue(KIND_CLEAR, C_ZERO, C_ZERO, C_ZERO);
    repeat (MAX_NODES - 1) issue(KIND_APPEND, rand_coord(), rand_coord(), rand_coord());
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    cz = COORD_W'($urandom);
    issue(KIND_APPEND, cx, cy, cz);
    issue(KIND_APPEND, rand_coord(), rand_coord(), rand_coord());
    issue(KIND_APPEND, C_MAX, C_MAX, C_MAX);
    issue(KIND_QUERY, cx, cy, cz);
    issue(KIND_MARK, C_ZERO, C_ZERO, C_ZERO);
    drain();
    write_radius(RADIUS_W'(3000));
    issue(KIND_QUERY, cx, cy, cz);
    issue(KIND_QUERY, rand_coord(), rand_coord(), rand_coord());
    issue(KIND_CLEAR, C_ZERO, C_ZERO, C_ZERO);
    drain();

    // Random part: mostly clustered append and query sequences, with some noise.
    hold_req    = 1'b1;
    start_count = issued;
    while (issued - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        case ($urandom_range(0, 9))
          0:       rad = 0;
          1:       rad = (1 << RADIUS_W) - 1;
          2, 3:    rad = $urandom_range(0, (1 << RADIUS_W) - 1);
          default: rad = $urandom_range(0, 60);
        endcase
        write_radius(RADIUS_W'(rad));
      end
      if (table_fill > TABLE_CAP || $urandom_range(0, 3) != 0)
        issue(KIND_CLEAR, rand_coord(), rand_coord(), rand_coord());
      case ($urandom_range(0, 9))
        0:       n_app = 0;
        1:       n_app = $urandom_range(20, 120);
        default: n_app = $urandom_range(1, 10);
      endcase
      mark_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_app) : -1;
      spread  = $urandom_range(1, 400);
      cx      = rand_coord();
      cy      = rand_coord();
      cz      = rand_coord();
      for (int i = 0; i <= n_app; i++) begin
        if (i == mark_at) issue(KIND_MARK, rand_coord(), rand_coord(), rand_coord());
        if (i < n_app)
          issue(KIND_APPEND, near_coord(cx, spread), near_coord(cy, spread),
                near_coord(cz, spread));
      end
      n_q = $urandom_range(1, 6);
      repeat (n_q) begin
        if ($urandom_range(0, 3) == 0)
          issue(KIND_QUERY, rand_coord(), rand_coord(), rand_coord());
        else
          issue(KIND_QUERY, near_coord(cx, spread), near_coord(cy, spread),
                near_coord(cz, spread));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3))
          issue(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord());
      end
    end

    drain();
    if (mismatch_total == 0 && answers_owed == 0) begin
      $display("[nearest_node_attractor_query_unit] OK");
    end else begin
      $display("[nearest_node_attractor_query_unit] ERROR");
    end
    $finish;
  end

endmodule
